>>> rtl/vic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vic_pkg: shared types and constants of the vblank interval checker
// Fixed field widths, reset values and the payloads that pass between stages.
// ----------------------------------------------------------------------------
package vic_pkg;

  localparam int unsigned PERIOD_W = 40;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 40'd4266666752;
  localparam logic [63:0]         S64_POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0]         S64_NEG_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [63:0]         ALL64        = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [62:0]         GAP_ALL      = 63'h7FFF_FFFF_FFFF_FFFF;

  // per-event values carried down to the statistics stage
  typedef struct packed {
    logic        upd;       // later event in order: interval stats apply
    logic        ord_bad;   // sequence or stamp did not increase
    logic [63:0] dt;        // stamp - previous stamp
    logic [63:0] skip_inc;  // seq - previous seq - 1
    logic [63:0] lag;       // arrival - stamp, saturated signed
  } vic_side_t;

  typedef struct packed {
    vic_side_t   side;
    logic        ns_ok;     // stamp and arrival both positive
    logic [63:0] delta;     // seq - previous seq
    logic [63:0] mag;       // |arrival - stamp|
  } vic_front_t;

  typedef struct packed {
    vic_side_t   side;
    logic        base_ok;   // positive times, offset within one period
    logic [63:0] diff;      // |dt*2^F - delta*period|, both saturated
  } vic_chk_t;

  // first member in the highest bits, sample_ok in bit 0
  typedef struct packed {
    logic [63:0] lag_max;
    logic [63:0] lag_min;
    logic [62:0] gap_sum;
    logic [62:0] gap_max;
    logic [62:0] gap_min;
    logic [63:0] skipped_total;
    logic [31:0] invalid_total;
    logic [31:0] samples_seen;
    logic        sample_ok;
  } vic_result_t;

endpackage

>>> rtl/vic_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vic_front: event intake stage
// Registers the request together with its deltas to the previous event, the
// arrival offset and the ordering checks.
// ----------------------------------------------------------------------------
module vic_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [63:0]        seq_number_i,
  input  logic signed [63:0] stamp_ns_i,
  input  logic [62:0]        arrival_ns_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vic_pkg::vic_front_t out_o
);
  import vic_pkg::*;

  logic               valid_q;
  logic               seen_q;
  logic [63:0]        prev_seq_q;
  logic signed [63:0] prev_stamp_q;
  logic               accept;
  logic [63:0]        diff_a;
  logic [63:0]        diff_b;
  logic               neg;
  vic_front_t         front_d;
  vic_front_t         front_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_o       = front_q;

  always_comb begin
    diff_a = 64'(arrival_ns_i) - stamp_ns_i;
    diff_b = stamp_ns_i - 64'(arrival_ns_i);
    neg    = $signed({1'b0, arrival_ns_i}) < stamp_ns_i;

    front_d.mag   = neg ? diff_b : diff_a;
    front_d.ns_ok = (stamp_ns_i != '0) && !stamp_ns_i[63] && (arrival_ns_i != '0);
    front_d.delta = seq_number_i - prev_seq_q;

    front_d.side.ord_bad  = seen_q && ((seq_number_i <= prev_seq_q) ||
                                       !(prev_stamp_q < stamp_ns_i));
    front_d.side.upd      = seen_q && !front_d.side.ord_bad;
    front_d.side.dt       = stamp_ns_i - prev_stamp_q;
    front_d.side.skip_inc = seq_number_i + ~prev_seq_q;
    // negative offset wraps to its own two's complement value
    front_d.side.lag      = neg ? diff_a : (diff_a[63] ? S64_POS_MAX : diff_a);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      seen_q       <= 1'b0;
      prev_seq_q   <= '0;
      prev_stamp_q <= '0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (accept) begin
        seen_q       <= 1'b1;
        prev_seq_q   <= seq_number_i;
        prev_stamp_q <= stamp_ns_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      front_q <= front_d;
    end
  end

endmodule

>>> rtl/vic_expect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vic_expect: expected interval pipeline
// Four stages: partial products of delta * period, two partial sums, final
// sum with saturation, and the absolute difference to the scaled interval.
// ----------------------------------------------------------------------------
module vic_expect #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [vic_pkg::PERIOD_W-1:0]    period_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  vic_pkg::vic_front_t             in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output vic_pkg::vic_chk_t               out_o
);
  import vic_pkg::*;

  localparam logic [63:0] DT_LIM = ALL64 >> FRAC_BITS;

  logic [3:0]  valid_q;
  logic [3:0]  rdy;

  vic_side_t   s1_side_q, s2_side_q, s3_side_q;
  logic        s1_ok_q, s2_ok_q, s3_ok_q;
  logic [63:0] s1_dtq_q, s2_dtq_q, s3_dtq_q;
  logic [63:0] s1_pa_q, s1_pb_q;
  logic [39:0] s1_pc_q, s1_pd_q;
  logic [95:0] s2_lo_q;
  logic [71:0] s2_hi_q;
  logic [63:0] s3_exp_q;
  vic_chk_t    s4_q;

  logic        base_ok;
  logic [63:0] dtq;
  logic [103:0] prod;
  logic [63:0] expq;
  logic [63:0] diff;

  assign rdy[3]      = !valid_q[3] || out_ready_i;
  assign rdy[2]      = !valid_q[2] || rdy[3];
  assign rdy[1]      = !valid_q[1] || rdy[2];
  assign rdy[0]      = !valid_q[0] || rdy[1];
  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[3];
  assign out_o       = s4_q;

  always_comb begin
    base_ok = in_i.ns_ok && (in_i.mag <= ({24'h0, period_i} >> FRAC_BITS));
    dtq     = (in_i.side.dt > DT_LIM) ? ALL64 : (in_i.side.dt << FRAC_BITS);
    prod    = {8'h0, s2_lo_q} + {s2_hi_q, 32'h0};
    expq    = (prod[103:64] != '0) ? ALL64 : prod[63:0];
    diff    = (s3_dtq_q >= s3_exp_q) ? (s3_dtq_q - s3_exp_q) : (s3_exp_q - s3_dtq_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) valid_q[0] <= in_valid_i;
      if (rdy[1]) valid_q[1] <= valid_q[0];
      if (rdy[2]) valid_q[2] <= valid_q[1];
      if (rdy[3]) valid_q[3] <= valid_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      s1_side_q <= in_i.side;
      s1_ok_q   <= base_ok;
      s1_dtq_q  <= dtq;
      s1_pa_q   <= in_i.delta[31:0]  * period_i[31:0];
      s1_pb_q   <= in_i.delta[63:32] * period_i[31:0];
      s1_pc_q   <= in_i.delta[31:0]  * period_i[39:32];
      s1_pd_q   <= in_i.delta[63:32] * period_i[39:32];
    end
    if (rdy[1] && valid_q[0]) begin
      s2_side_q <= s1_side_q;
      s2_ok_q   <= s1_ok_q;
      s2_dtq_q  <= s1_dtq_q;
      s2_lo_q   <= {32'h0, s1_pa_q} + {s1_pb_q, 32'h0};
      s2_hi_q   <= {32'h0, s1_pc_q} + {s1_pd_q, 32'h0};
    end
    if (rdy[2] && valid_q[1]) begin
      s3_side_q <= s2_side_q;
      s3_ok_q   <= s2_ok_q;
      s3_dtq_q  <= s2_dtq_q;
      s3_exp_q  <= expq;
    end
    if (rdy[3] && valid_q[2]) begin
      s4_q.side    <= s3_side_q;
      s4_q.base_ok <= s3_ok_q;
      s4_q.diff    <= diff;
    end
  end

endmodule

>>> rtl/vic_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vic_stats: statistics and result register
// Final validity decision, saturating counters and interval / lag extremes.
// The accumulators double as the result register.
// ----------------------------------------------------------------------------
module vic_stats #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [vic_pkg::PERIOD_W-1:0] period_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  vic_pkg::vic_chk_t            in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output vic_pkg::vic_result_t         out_o
);
  import vic_pkg::*;

  logic                  valid_q;
  logic                  ok_q;
  logic [COUNT_BITS-1:0] events_q;
  logic [COUNT_BITS-1:0] bad_q;
  logic [63:0]           skip_q;
  logic [62:0]           gap_min_q, gap_max_q, gap_sum_q;
  logic [63:0]           lag_min_q, lag_max_q;

  logic                  load;
  logic                  ok;
  logic [62:0]           gap;
  logic [64:0]           skip_sum;
  logic [63:0]           gap_add;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;

  always_comb begin
    ok       = in_i.base_ok && !in_i.side.ord_bad &&
               (!in_i.side.upd || (in_i.diff <= {26'h0, period_i[39:2]}));
    gap      = in_i.side.dt[63] ? GAP_ALL : in_i.side.dt[62:0];
    skip_sum = {1'b0, skip_q} + {1'b0, in_i.side.skip_inc};
    gap_add  = {1'b0, gap_sum_q} + {1'b0, gap};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      ok_q      <= 1'b0;
      events_q  <= '0;
      bad_q     <= '0;
      skip_q    <= '0;
      gap_min_q <= GAP_ALL;
      gap_max_q <= '0;
      gap_sum_q <= '0;
      lag_min_q <= S64_POS_MAX;
      lag_max_q <= S64_NEG_MIN;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (load) begin
        ok_q <= ok;
        if (events_q != '1) events_q <= events_q + 1'b1;
        if (!ok && (bad_q != '1)) bad_q <= bad_q + 1'b1;
        if (in_i.side.upd) begin
          skip_q    <= skip_sum[64] ? ALL64 : skip_sum[63:0];
          if (gap < gap_min_q) gap_min_q <= gap;
          if (gap > gap_max_q) gap_max_q <= gap;
          gap_sum_q <= gap_add[63] ? GAP_ALL : gap_add[62:0];
        end
        if ($signed(in_i.side.lag) < $signed(lag_min_q)) lag_min_q <= in_i.side.lag;
        if ($signed(lag_max_q) < $signed(in_i.side.lag)) lag_max_q <= in_i.side.lag;
      end
    end
  end

  always_comb begin
    out_o.sample_ok     = ok_q;
    out_o.samples_seen  = 32'(events_q);
    out_o.invalid_total = 32'(bad_q);
    out_o.skipped_total = skip_q;
    out_o.gap_min       = gap_min_q;
    out_o.gap_max       = gap_max_q;
    out_o.gap_sum       = gap_sum_q;
    out_o.lag_min       = lag_min_q;
    out_o.lag_max       = lag_max_q;
  end

endmodule

>>> rtl/vblank_interval_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vblank_interval_checker: frame event interval and latency checker
// Checks each frame event against the nominal period and keeps statistics.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one request per frame event (sequence number, hardware
//   timestamp, arrival time). Master stream: one status per event with
//   sample_ok and the running counters, extremes and sums.
//   cfg_we_i writes the nominal period (ns, FRAC_BITS fraction bits);
//   write it only while no event is in flight.
//   A taken request is registered by the intake, partial-product, two adder,
//   difference and statistics stages in turn. Throughput: one event per
//   cycle unless the master stream stalls; delta * period is split into
//   partial products of 32-bit delta halves, summed over two pipeline stages.
//   Reset clears all statistics, the previous-event registers and every
//   stage valid; the period returns to its reset value.
//   When the receiver stalls, the status stays in the result register and
//   empty stages still fill; s_axis_tready drops only once every stage holds
//   an event.
// ----------------------------------------------------------------------------
module vblank_interval_checker #(
  parameter int unsigned FRAC_BITS  = 8,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [vic_pkg::PERIOD_W-1:0] cfg_wdata_i,   // period_q8
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // seq_number[63:0], stamp_ns[127:64], arrival_ns[190:128], zero [191]
  input  logic [191:0]                 s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // sample_ok[0], samples_seen[32:1], invalid_total[64:33],
  // skipped_total[128:65], gap_min[191:129], gap_max[254:192],
  // gap_sum[317:255], lag_min[381:318], lag_max[445:382], zero [447:446]
  output logic [447:0]                 m_axis_tdata
);
  import vic_pkg::*;

  logic [PERIOD_W-1:0] period_q;
  logic                front_valid, front_ready;
  vic_front_t          front;
  logic                chk_valid, chk_ready;
  vic_chk_t            chk;
  vic_result_t         result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  vic_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .seq_number_i (s_axis_tdata[63:0]),
    .stamp_ns_i   ($signed(s_axis_tdata[127:64])),
    .arrival_ns_i (s_axis_tdata[190:128]),
    .out_valid_o  (front_valid),
    .out_ready_i  (front_ready),
    .out_o        (front)
  );

  vic_expect #(
    .FRAC_BITS (FRAC_BITS)
  ) u_expect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .period_i    (period_q),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_i        (front),
    .out_valid_o (chk_valid),
    .out_ready_i (chk_ready),
    .out_o       (chk)
  );

  vic_stats #(
    .COUNT_BITS (COUNT_BITS)
  ) u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .period_i    (period_q),
    .in_valid_i  (chk_valid),
    .in_ready_o  (chk_ready),
    .in_i        (chk),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (result)
  );

  assign m_axis_tdata = {2'b00, result};

endmodule
